/* rtl/depq_pkg.sv */
// shared types and constants of the double-ended priority queue
package depq_pkg;

  localparam int VALUE_W           = 32;
  localparam int COUNT_OUT_W       = 7;
  localparam int DEPQ_DEFAULT_DEPTH = 64;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DEL_MAX = 2'd1,
    CMD_DEL_MIN = 2'd2
  } depq_cmd_t;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [VALUE_W-1:0]  value;
  } depq_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  max_value;
    logic signed [VALUE_W-1:0]  min_value;
    logic [COUNT_OUT_W-1:0]     entry_count;
    logic                       is_empty;
    logic                       insert_dropped;
    logic                       delete_ignored;
  } depq_out_t;

  // operation broadcast to every cell in the same cycle
  typedef struct packed {
    logic                       ins;
    logic                       del_max;
    logic                       del_min;
    logic signed [VALUE_W-1:0]  value;
  } depq_op_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic                       valid;
    logic                       ge;
  } depq_link_t;

endpackage

/* rtl/double_ended_priority_queue_core.sv */
// top level of the double-ended priority queue
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall   depq_in_t  (cmd, value)
//  out      output     out_valid/out_stall depq_out_t (max, min, count, flags)
//
// an accepted request updates every cell of the chain together; the result
// register is then loaded from the cell registers once the output is free. the
// cell chain and the single result register lie between request and result.
// reset clears the count, the pending flag, the cell valid bits and out_valid.
// a stalled result holds the next request in the pending stage; a new request
// is taken while a finished result waits on out_stall.
module double_ended_priority_queue_core
  import depq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPQ_DEFAULT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  depq_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output depq_out_t out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]             count_r, count_nxt;
  logic                      pend_r;
  logic                      dropped_r, ignored_r;
  logic                      out_valid_r;
  depq_out_t                 out_r;
  logic                      in_acc, out_load, full, empty;
  logic                      dropped, ignored;
  depq_op_t                  op;
  logic signed [VALUE_W-1:0] max_value, min_value;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = pend_r;
  assign out_load = pend_r && (!out_valid_r || !out_stall);
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    op        = '{ins: 1'b0, del_max: 1'b0, del_min: 1'b0, value: in_data.value};
    count_nxt = count_r;
    dropped   = 1'b0;
    ignored   = 1'b0;
    if (in_acc) begin
      unique case (in_data.cmd)
        CMD_INSERT: begin
          if (full) begin
            dropped = 1'b1;
          end else begin
            op.ins    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_DEL_MAX, CMD_DEL_MIN: begin
          if (empty) begin
            ignored = 1'b1;
          end else begin
            op.del_max = (in_data.cmd == CMD_DEL_MAX);
            op.del_min = (in_data.cmd == CMD_DEL_MIN);
            count_nxt  = count_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  depq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .max_value (max_value),
    .min_value (min_value)
  );

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        pend_r <= 1'b1;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      dropped_r <= dropped;
      ignored_r <= ignored;
    end
    if (out_load) begin
      out_r.max_value      <= max_value;
      out_r.min_value      <= min_value;
      out_r.entry_count    <= count_ext[COUNT_OUT_W-1:0];
      out_r.is_empty       <= empty;
      out_r.insert_dropped <= dropped_r;
      out_r.delete_ignored <= ignored_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("count above depth");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.cmd == CMD_INSERT) && !full |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.is_empty |-> out_r.max_value == 0 && out_r.min_value == 0)
    else $error("empty result with nonzero extremes");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.insert_dropped && out_r.delete_ignored))
    else $error("both flags set");

endmodule

/* rtl/depq_cell.sv */
// one storage cell of the sorted chain
module depq_cell
  import depq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  depq_op_t   op,
  input  depq_link_t left_i,
  input  depq_link_t right_i,
  output depq_link_t link_o
);

  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic                      valid_r, valid_nxt;
  logic                      ge;

  assign ge = valid_r && (value_r >= op.value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (op.ins) begin
      valid_nxt = valid_r | left_i.valid;
      if (!ge) begin
        value_nxt = left_i.ge ? op.value : left_i.value;
      end
    end else if (op.del_max) begin
      value_nxt = right_i.value;
      valid_nxt = right_i.valid;
    end else if (op.del_min) begin
      valid_nxt = valid_r & right_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign link_o = '{value: value_r, valid: valid_r, ge: ge};

endmodule

/* rtl/depq_chain.sv */
// row of sorted cells with max and min taps
module depq_chain
  import depq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPQ_DEFAULT_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  depq_op_t                  op,
  output logic signed [VALUE_W-1:0] max_value,
  output logic signed [VALUE_W-1:0] min_value
);

  depq_link_t links [QUEUE_DEPTH+2];

  // boundary links: left end always precedes the new value, right end is empty
  assign links[0]             = '{value: '0, valid: 1'b1, ge: 1'b1};
  assign links[QUEUE_DEPTH+1] = '{value: '0, valid: 1'b0, ge: 1'b0};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    depq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .left_i  (links[i]),
      .right_i (links[i+2]),
      .link_o  (links[i+1])
    );
  end

  assign max_value = links[1].valid ? links[1].value : '0;

  // last valid cell holds the minimum
  always_comb begin
    min_value = '0;
    for (int i = 1; i <= QUEUE_DEPTH; i++) begin
      if (links[i].valid && !links[i+1].valid) begin
        min_value = min_value | links[i].value;
      end
    end
  end

endmodule
